### rtl/ucfp_pkg.sv
// ----------------------------------------------------------------------------
// ucfp_pkg - shared types and constants for the serial CAN frame parser
// Frame layout constants, sequencer states, result kinds and the
// structures that pass between the sequencer, the buffer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ucfp_pkg;

	// Frame buffer geometry
	localparam int BufDepth = 20;
	localparam int AddrW    = 5;

	// Wire protocol
	localparam logic [7:0]       SyncByte     = 8'hAA;
	localparam logic [7:0]       CmdByte      = 8'h55;
	localparam logic [3:0]       DataNibble   = 4'hC;
	localparam int               ExtBit       = 5;
	localparam logic [AddrW-1:0] SumLastOff   = AddrW'(BufDepth - 1);
	localparam logic [AddrW-1:0] DataOverhead = AddrW'(5);
	localparam logic [AddrW-1:0] FirstDataOff = AddrW'(4);
	localparam logic [3:0]       MaxDlc       = 4'd8;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_BAD_DATA = 2'd1,
		KIND_CMD_OK   = 2'd2,
		KIND_CMD_BAD  = 2'd3
	} ucfp_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK0,
		ST_B0,
		ST_SCAN,
		ST_RESYNC,
		ST_B1,
		ST_SUM,
		ST_ID0,
		ST_ID1,
		ST_DATA,
		ST_OUT
	} ucfp_state_t;

	// Buffer memory port request
	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [AddrW-1:0] raddr;
	} ucfp_mem_req_t;

	// One decoded result
	typedef struct packed {
		ucfp_kind_t  kind;
		logic [15:0] can_id;
		logic [3:0]  dlc;
		logic        extended;
		logic [63:0] payload;
	} ucfp_res_t;

	// Circular index add, both operands at most BufDepth
	function automatic logic [AddrW-1:0] ucfp_wrap(input logic [AddrW-1:0] a,
			input logic [AddrW-1:0] b);
		logic [AddrW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AddrW+1)'(BufDepth)) begin
			s = s - (AddrW+1)'(BufDepth);
		end
		return s[AddrW-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/usb_can_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// usb_can_serial_frame_parser - serial CAN adapter frame parser
// Bytes from the adapter link are taken one per transfer into a 20-byte
// circular frame buffer held in a synchronous memory. After each byte the
// sequencer walks the buffer through the single memory read port, one byte
// per cycle: it drops bytes up to the next 0xAA sync byte, checks 20-byte
// command frames (0xAA 0x55) against their 8-bit sum over bytes 2..18, and
// decodes data frames (info byte 0xCx, DLC+5 bytes) into identifier, DLC,
// extended flag and payload. Each byte is stored on its transfer; the next
// byte is taken only once the sequencer has walked the buffer and, with a
// result, handed it to the output slot. At most one result per byte is
// given through an output register, so a new byte may be taken while a
// result waits; the sequencer stalls only when a second result meets a
// full slot.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_can_serial_frame_parser
	import ucfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [15:0]      can_id,
	output logic [3:0]       dlc,
	output logic             extended,
	output logic [63:0]      payload
);

	ucfp_mem_req_t mem_req;
	logic [7:0]    rd_data;
	logic          res_valid;
	logic          res_ready;
	ucfp_res_t     res;
	ucfp_res_t     res_q;
	logic          out_valid_q;

	ucfp_buf u_buf (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	ucfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output slot: free when empty or being emptied
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign can_id    = res_q.can_id;
	assign dlc       = res_q.dlc;
	assign extended  = res_q.extended;
	assign payload   = res_q.payload;

endmodule

`default_nettype wire

### rtl/ucfp_buf.sv
// ----------------------------------------------------------------------------
// ucfp_buf - frame byte store
// Single-port-write, single-port-read synchronous memory holding the
// circular frame buffer; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfp_buf
	import ucfp_pkg::*;
(
	input  wire logic          clk,
	input  wire ucfp_mem_req_t req,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [BufDepth];

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/ucfp_seq.sv
// ----------------------------------------------------------------------------
// ucfp_seq - buffer pointers and frame sequencer
// Keeps head and fill count of the circular buffer, pushes each received
// byte, then walks the buffer through the memory read port to resync,
// check command frames and decode data frames.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfp_seq
	import ucfp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	output ucfp_mem_req_t      mem_req,
	input  wire logic [7:0]    rd_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output ucfp_res_t          res
);

	ucfp_state_t      state_q, state_d;
	logic [AddrW-1:0] head_q;
	logic [AddrW-1:0] count_q;
	logic [AddrW-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       info_q;
	logic [15:0]      id_q;
	logic [63:0]      payload_q;
	ucfp_kind_t       kind_q;
	logic [AddrW-1:0] drop_q;

	logic             in_fire;
	logic             full;
	logic             drop_en;
	logic [AddrW-1:0] drop_n;
	logic             re;
	logic [AddrW-1:0] roff;
	logic             is_sync;
	logic             is_cmd;
	logic             is_data;
	logic [AddrW-1:0] rd_exp;
	logic [3:0]       dlc;
	logic             dlc_ok;
	logic [AddrW-1:0] data_last;
	logic [AddrW-1:0] count_m1;
	logic [AddrW-1:0] remain;
	logic [2:0]       lane;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign full      = (count_q == AddrW'(BufDepth));
	assign is_sync   = (rd_data == SyncByte);
	assign is_cmd    = (rd_data == CmdByte);
	assign is_data   = (rd_data[7:4] == DataNibble);
	assign rd_exp    = {1'b0, rd_data[3:0]} + DataOverhead;
	assign dlc       = info_q[3:0];
	assign dlc_ok    = (dlc != 4'd0) && (dlc <= MaxDlc);
	assign data_last = {1'b0, dlc} + (FirstDataOff - AddrW'(1));
	assign count_m1  = count_q - AddrW'(1);
	assign remain    = count_q - idx_q;
	assign lane      = 3'(idx_q - FirstDataOff);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_CHK0;
			end
			ST_CHK0: begin
				state_d = (count_q < AddrW'(2)) ? ST_IDLE : ST_B0;
			end
			ST_B0: begin
				state_d = is_sync ? ST_B1 : ST_SCAN;
			end
			ST_SCAN: begin
				if (is_sync) begin
					state_d = (remain < AddrW'(2)) ? ST_IDLE : ST_RESYNC;
				end else if (idx_q == count_m1) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESYNC: begin
				state_d = ST_B1;
			end
			ST_B1: begin
				if (is_cmd) begin
					state_d = full ? ST_SUM : ST_IDLE;
				end else if (is_data) begin
					state_d = (count_q >= rd_exp) ? ST_ID0 : ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (idx_q == SumLastOff) state_d = ST_OUT;
			end
			ST_ID0: begin
				state_d = ST_ID1;
			end
			ST_ID1: begin
				state_d = dlc_ok ? ST_DATA : ST_OUT;
			end
			ST_DATA: begin
				if (idx_q == data_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Read requests, front drops and result handshake
	always_comb begin
		re        = 1'b0;
		roff      = '0;
		drop_en   = 1'b0;
		drop_n    = '0;
		res_valid = 1'b0;
		case (state_q)
			ST_CHK0: begin
				re = (count_q >= AddrW'(2));
			end
			ST_B0, ST_RESYNC: begin
				re   = 1'b1;
				roff = AddrW'(1);
			end
			ST_SCAN: begin
				if (is_sync) begin
					drop_en = 1'b1;
					drop_n  = idx_q;
				end else if (idx_q == count_m1) begin
					// no sync byte held: empty the buffer
					drop_en = 1'b1;
					drop_n  = count_q;
				end else begin
					re   = 1'b1;
					roff = idx_q + AddrW'(1);
				end
			end
			ST_B1: begin
				if (is_cmd) begin
					re   = full;
					roff = AddrW'(2);
				end else if (is_data) begin
					re   = (count_q >= rd_exp);
					roff = AddrW'(2);
				end else begin
					drop_en = 1'b1;
					drop_n  = AddrW'(1);
				end
			end
			ST_SUM: begin
				if (idx_q != SumLastOff) begin
					re   = 1'b1;
					roff = idx_q + AddrW'(1);
				end
			end
			ST_ID0: begin
				re   = 1'b1;
				roff = AddrW'(3);
			end
			ST_ID1: begin
				re   = dlc_ok;
				roff = FirstDataOff;
			end
			ST_DATA: begin
				if (idx_q != data_last) begin
					re   = 1'b1;
					roff = idx_q + AddrW'(1);
				end
			end
			ST_OUT: begin
				res_valid = 1'b1;
				drop_en   = res_ready;
				drop_n    = drop_q;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// Memory port: push on transfer, read relative to head
	always_comb begin
		mem_req.we    = in_fire;
		mem_req.waddr = ucfp_wrap(head_q, count_q);
		mem_req.wdata = rx_byte;
		mem_req.re    = re;
		mem_req.raddr = ucfp_wrap(head_q, roff);
	end

	// Control state: state, head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				// a full buffer loses its oldest byte
				if (full) begin
					head_q <= ucfp_wrap(head_q, AddrW'(1));
				end else begin
					count_q <= count_q + AddrW'(1);
				end
			end else if (drop_en) begin
				head_q  <= ucfp_wrap(head_q, drop_n);
				count_q <= (drop_n >= count_q) ? '0 : count_q - drop_n;
			end
		end
	end

	// Datapath: scan index, checksum, decoded fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_B0: begin
				idx_q <= AddrW'(1);
			end
			ST_SCAN: begin
				idx_q <= idx_q + AddrW'(1);
			end
			ST_B1: begin
				info_q    <= rd_data;
				idx_q     <= AddrW'(2);
				sum_q     <= '0;
				payload_q <= '0;
			end
			ST_SUM: begin
				if (idx_q != SumLastOff) begin
					sum_q <= sum_q + rd_data;
					idx_q <= idx_q + AddrW'(1);
				end else begin
					id_q   <= '0;
					info_q <= '0;
					if (sum_q == rd_data) begin
						kind_q <= KIND_CMD_OK;
						drop_q <= AddrW'(BufDepth);
					end else begin
						kind_q <= KIND_CMD_BAD;
						drop_q <= AddrW'(1);
					end
				end
			end
			ST_ID0: begin
				id_q[7:0] <= rd_data;
			end
			ST_ID1: begin
				id_q[15:8] <= rd_data;
				idx_q      <= FirstDataOff;
				drop_q     <= {1'b0, dlc} + DataOverhead;
				kind_q     <= dlc_ok ? KIND_DATA : KIND_BAD_DATA;
			end
			ST_DATA: begin
				for (int i = 0; i < 8; i++) begin
					if (lane == 3'(i)) payload_q[8*i +: 8] <= rd_data;
				end
				idx_q <= idx_q + AddrW'(1);
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign res.kind     = kind_q;
	assign res.can_id   = id_q;
	assign res.dlc      = info_q[3:0];
	assign res.extended = info_q[ExtBit];
	assign res.payload  = payload_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AddrW'(BufDepth))
		else $error("fill count beyond buffer depth");

	a_sum_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> full)
		else $error("checksum walk on a partly filled buffer");

	a_raddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> (mem_req.raddr < AddrW'(BufDepth)))
		else $error("buffer read address out of range");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> (roff < count_q))
		else $error("read of a byte not held in the buffer");

	a_data_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (idx_q >= FirstDataOff && idx_q <= data_last))
		else $error("data byte index outside frame");

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - serial CAN frame parser
// Feeds adapter bytes through the input transfer with random gaps. A shadow
// frame buffer in the bench decodes the same stream and queues the frames it
// expects. Every output transfer is compared field by field with the oldest
// queued frame. Directed sync, data and command cases come first, then a long
// random stream of mostly well-formed frames with noise and cut-off frames,
// and finally a long output hold-off that backs the parser up.
// ----------------------------------------------------------------------------

module testbench
	import ucfp_pkg::*;
();

	localparam int  SumBytes    = 17;
	localparam int  HoldCycles  = 600;
	localparam int  DrainCycles = 100;
	localparam int  CycleLimit  = 600000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] can_id;
	logic [3:0]  dlc;
	logic        extended;
	logic [63:0] payload;

	// Shadow frame buffer and queue of frames still to come out
	logic [7:0]  shadow_buf [BufDepth];
	int          shadow_count;
	ucfp_res_t   pending_frames [$];

	int          mismatches = 0;
	int          sent_bytes;
	int          cycles = 0;
	bit          no_idle;
	// hold-off requests from the test sequence, taken up by the output side
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	usb_can_serial_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.can_id    (can_id),
		.dlc       (dlc),
		.extended  (extended),
		.payload   (payload)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout, %0d frames outstanding", $time, pending_frames.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drop n bytes from the front of the shadow buffer
	function automatic void shadow_drop(input int n);
		int i;
		if (n >= shadow_count) begin
			shadow_count = 0;
			return;
		end
		for (i = 0; i < shadow_count - n; i++)
			shadow_buf[i] = shadow_buf[i + n];
		shadow_count = shadow_count - n;
	endfunction

	// Push one byte into the shadow buffer; returns 1 when a frame is complete
	function automatic bit parse_byte(input logic [7:0] b, output ucfp_res_t frame);
		int         i;
		int         k;
		int         need;
		logic [7:0] sum;
		logic [3:0] code;
		frame = '0;
		if (shadow_count >= BufDepth)
			shadow_drop(1);
		shadow_buf[shadow_count] = b;
		shadow_count++;
		if (shadow_count < 2)
			return 1'b0;

		// lost sync: skip to the next sync byte
		if (shadow_buf[0] != SyncByte) begin
			k = shadow_count;
			for (i = 0; i < shadow_count; i++) begin
				if (shadow_buf[i] == SyncByte) begin
					k = i;
					break;
				end
			end
			if (k == shadow_count) begin
				shadow_count = 0;
				return 1'b0;
			end
			shadow_drop(k);
			if (shadow_count < 2)
				return 1'b0;
		end

		// command frame: full buffer, then checksum over bytes 2..18
		if (shadow_buf[1] == CmdByte) begin
			if (shadow_count < BufDepth)
				return 1'b0;
			sum = 8'd0;
			for (i = 2; i < 2 + SumBytes; i++)
				sum = sum + shadow_buf[i];
			if (sum != shadow_buf[BufDepth - 1]) begin
				shadow_drop(1);
				frame.kind = KIND_CMD_BAD;
			end else begin
				shadow_drop(BufDepth);
				frame.kind = KIND_CMD_OK;
			end
			return 1'b1;
		end

		// data frame: DLC+5 bytes
		if (shadow_buf[1][7:4] == DataNibble) begin
			code = shadow_buf[1][3:0];
			need = int'(code) + int'(DataOverhead);
			if (shadow_count < need)
				return 1'b0;
			frame.can_id   = {shadow_buf[3], shadow_buf[2]};
			frame.dlc      = code;
			frame.extended = shadow_buf[1][ExtBit];
			if (code == 4'd0 || code > MaxDlc) begin
				frame.kind = KIND_BAD_DATA;
			end else begin
				frame.kind = KIND_DATA;
				for (i = 0; i < int'(code); i++)
					frame.payload[8*i +: 8] = shadow_buf[int'(FirstDataOff) + i];
			end
			shadow_drop(need);
			return 1'b1;
		end

		// unknown info byte
		shadow_drop(1);
		return 1'b0;
	endfunction

	// One input transfer; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		ucfp_res_t frame;
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_bytes++;
		if (parse_byte(b, frame))
			pending_frames.insert(pending_frames.size(), frame);
		@(negedge clk);
	endtask

	// Data frame with the given info nibble; only the first keep bytes are sent
	task automatic send_data_frame(input logic [3:0] code, input int keep);
		logic [15:0] id;
		int          i;
		case ($urandom_range(0, 7))
			0:       id = 16'h0000;
			1:       id = 16'hFFFF;
			default: id = 16'($urandom);
		endcase
		for (i = 0; i < int'(code) + int'(DataOverhead) && i < keep; i++) begin
			case (i)
				0:       send_byte(SyncByte);
				1:       send_byte({DataNibble, code});
				2:       send_byte(id[7:0]);
				3:       send_byte(id[15:8]);
				default: send_byte(8'($urandom));
			endcase
		end
	endtask

	// Command frame with a good or corrupted checksum, cut after keep bytes
	task automatic send_command_frame(input bit good, input int keep);
		logic [7:0] sum;
		logic [7:0] b;
		int         i;
		sum = 8'd0;
		for (i = 0; i < BufDepth && i < keep; i++) begin
			if (i == 0) begin
				send_byte(SyncByte);
			end else if (i == 1) begin
				send_byte(CmdByte);
			end else if (i < BufDepth - 1) begin
				b   = 8'($urandom);
				sum = sum + b;
				send_byte(b);
			end else begin
				send_byte(good ? sum : sum ^ (8'd1 << $urandom_range(0, 7)));
			end
		end
	endtask

	// Random data length code, mostly legal
	function automatic logic [3:0] pick_code();
		if ($urandom_range(0, 99) < 85)
			return 4'($urandom_range(1, 8));
		return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
	endfunction

	// One random piece of the stream
	task automatic send_random_piece();
		logic [3:0] code;
		logic [7:0] b;
		int         r;
		int         i;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			send_data_frame(pick_code(), BufDepth);
		end else if (r < 70) begin
			send_command_frame($urandom_range(0, 9) < 7, BufDepth);
		end else if (r < 82) begin
			// frame cut short, the next piece lands on top of it
			if ($urandom_range(0, 1)) begin
				code = pick_code();
				send_data_frame(code, $urandom_range(1, int'(code) + 4));
			end else begin
				send_command_frame(1'b1, $urandom_range(1, BufDepth - 1));
			end
		end else if (r < 92) begin
			for (i = 0; i < $urandom_range(1, 4); i++)
				send_byte(8'($urandom));
		end else begin
			// sync byte followed by an info byte of no known kind
			send_byte(SyncByte);
			b = 8'($urandom);
			while (b == CmdByte || b[7:4] == DataNibble)
				b = 8'($urandom);
			send_byte(b);
		end
	endtask

	// Output side: random stalls, calm stretches and one long hold-off
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each output transfer with the oldest expected frame
	always @(posedge clk) begin : check_results
		ucfp_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected frame, expected none, got kind %0d id %0h",
					$time, kind, can_id);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("can_id", 64'(want.can_id), 64'(can_id));
				check_field("dlc", 64'(want.dlc), 64'(dlc));
				check_field("extended", 64'(want.extended), 64'(extended));
				check_field("payload", want.payload, payload);
			end
		end
	end

	// Lost sync, unknown info byte and a lone byte
	task automatic test_sync_recovery();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SyncByte);
		send_byte(8'h12);
		send_byte(8'h37);
	endtask

	// Widest data frame with all ones, then a zero-length frame
	task automatic test_data_extremes();
		int i;
		send_byte(SyncByte);
		send_byte({DataNibble, MaxDlc});
		for (i = 0; i < int'(MaxDlc) + 3; i++)
			send_byte(8'hFF);
		send_byte(SyncByte);
		send_byte({DataNibble, 4'h0});
		send_byte(8'h00);
		send_byte(8'h00);
		// trailing byte is a sync byte and must be swallowed
		send_byte(SyncByte);
	endtask

	// Good and bad checksums; a bad one resyncs a byte at a time
	task automatic test_command_frames();
		int i;
		send_command_frame(1'b1, BufDepth);
		send_command_frame(1'b0, BufDepth);
		for (i = 0; i < 10; i++)
			send_command_frame($urandom_range(0, 1), BufDepth);
	endtask

	// Long random stream with a stretch of no idling on either side
	task automatic test_random_stream();
		while (sent_bytes < 1000) begin
			no_idle = (sent_bytes >= 450 && sent_bytes < 600);
			send_random_piece();
		end
		no_idle = 1'b0;
	endtask

	// Output held off while bytes keep coming
	task automatic test_backpressure();
		hold_reqs++;
		while (sent_bytes < 1150)
			send_data_frame(4'($urandom_range(1, 8)), BufDepth);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		shadow_count = 0;
		sent_bytes   = 0;
		no_idle      = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_sync_recovery();
		test_data_extremes();
		test_command_frames();
		test_random_stream();
		test_backpressure();

		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
